>>> hdl/sha256_pkg.sv
// Shared types and constants of the SHA-256 message digest block.
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned ROUNDS = 64;

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_FIRST,
        ST_PAD_FILL,
        ST_INIT,
        ST_ROUND,
        ST_FINISH,
        ST_DIGEST
    } state_t;

    typedef enum logic [2:0] {
        PH_READ_A,
        PH_READ_B,
        PH_SCHED,
        PH_ADD,
        PH_UPDATE
    } phase_t;

    typedef enum logic [1:0] {
        CONT_IDLE,
        CONT_PAD,
        CONT_FILL,
        CONT_DIGEST
    } cont_t;

endpackage

>>> hdl/sha256_message_digest.sv
// SHA-256 message digest: byte packing, padding, compression and digest output.

// The block takes one message byte per beat on the msg channel and returns the eight
// digest words, first word first, on the digest channel after a beat marked end of
// message. A full block passes through compression: a load of the working variables,
// 64 rounds, each in the phases read A, read B, schedule, add and update, and an add
// into the hash. The two read ports of the message schedule memory deliver the four
// schedule words of a round over two reads. Padding writes one word per cycle and may
// add a second block. The digest words leave one per accepted beat, and the block
// then starts over with the initial hash for the next message.
module sha256_message_digest (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      msg_valid,
    output logic                      msg_ready,
    input  sha256_pkg::msg_beat_t     msg,
    output logic                      digest_valid,
    input  logic                      digest_ready,
    output sha256_pkg::digest_beat_t  digest
);
    import sha256_pkg::*;

    function automatic word_t big_sigma0(word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    cont_t       cont_reg, cont_next;
    logic [5:0]  round_reg, round_next;
    logic [5:0]  pos_reg, pos_next;
    logic [3:0]  fill_reg, fill_next;
    logic        len_pass_reg, len_pass_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [63:0] bit_len_reg, bit_len_next;
    word_t       hash_reg [8];
    word_t       hash_next [8];

    word_t       word_reg, word_next;
    word_t       var_reg [8];
    word_t       var_next [8];
    word_t       hk_reg, hk_next;
    word_t       sig_reg, sig_next;
    word_t       w_reg, w_next;
    word_t       t1a_reg, t1a_next;

    word_t       sched_mem [16];
    word_t       rd0_reg, rd1_reg;
    logic [3:0]  ra0, ra1;
    logic        mem_we;
    logic [3:0]  mem_waddr;
    word_t       mem_wdata;

    logic [1:0]  slot;
    logic [4:0]  byte_shift;
    word_t       byte_word;
    word_t       pad_word;
    logic [3:0]  idx;
    word_t       w_sched;
    word_t       t1;
    word_t       t2;

    assign msg_ready          = (state_reg == ST_IDLE);
    assign digest_valid       = (state_reg == ST_DIGEST);
    assign digest.digest_word = hash_reg[out_idx_reg];
    assign digest.word_index  = out_idx_reg;
    assign digest.last_word   = (out_idx_reg == 3'd7);

    assign slot       = pos_reg[1:0];
    assign byte_shift = {~slot, 3'b000};
    assign byte_word  = (slot == 2'd0) ? {msg.data_byte, 24'b0}
                                       : (word_reg | ({24'b0, msg.data_byte} << byte_shift));
    assign pad_word   = (slot == 2'd0) ? {PAD_BYTE, 24'b0}
                                       : (word_reg | ({24'b0, PAD_BYTE} << byte_shift));

    assign idx     = round_reg[3:0];
    assign w_sched = rd0_reg + rd1_reg + sig_reg;
    assign t1      = t1a_reg + big_sigma1(var_reg[4])
                   + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]));
    assign t2      = big_sigma0(var_reg[0])
                   + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                   ^ (var_reg[1] & var_reg[2]));

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cont_next     = cont_reg;
        round_next    = round_reg;
        pos_next      = pos_reg;
        fill_next     = fill_reg;
        len_pass_next = len_pass_reg;
        out_idx_next  = out_idx_reg;
        bit_len_next  = bit_len_reg;
        hash_next     = hash_reg;
        word_next     = word_reg;
        var_next      = var_reg;
        hk_next       = hk_reg;
        sig_next      = sig_reg;
        w_next        = w_reg;
        t1a_next      = t1a_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx;
        mem_wdata     = w_sched;
        ra0           = idx;
        ra1           = idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.has_byte)
                    begin
                        word_next    = byte_word;
                        pos_next     = pos_reg + 6'd1;
                        bit_len_next = bit_len_reg + 64'd8;
                        if (slot == 2'd3)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_reg[5:2];
                            mem_wdata = byte_word;
                        end
                    end
                    if (msg.has_byte && (pos_reg == 6'd63))
                    begin
                        cont_next  = msg.end_of_message ? CONT_PAD : CONT_IDLE;
                        state_next = ST_INIT;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = ST_PAD_FIRST;
                    end
                end
            end
            ST_PAD_FIRST:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[5:2];
                mem_wdata = pad_word;
                pos_next  = 6'd0;
                if (pos_reg[5:2] == 4'd15)
                begin
                    cont_next  = CONT_FILL;
                    state_next = ST_INIT;
                end
                else
                begin
                    fill_next     = pos_reg[5:2] + 4'd1;
                    len_pass_next = (pos_reg[5:2] < 4'd14);
                    state_next    = ST_PAD_FILL;
                end
            end
            ST_PAD_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_reg;
                mem_wdata = '0;
                if (len_pass_reg && (fill_reg == 4'd14))
                begin
                    mem_wdata = bit_len_reg[63:32];
                end
                else if (len_pass_reg && (fill_reg == 4'd15))
                begin
                    mem_wdata = bit_len_reg[31:0];
                end
                if (fill_reg == 4'd15)
                begin
                    cont_next  = len_pass_reg ? CONT_DIGEST : CONT_FILL;
                    state_next = ST_INIT;
                end
                else
                begin
                    fill_next = fill_reg + 4'd1;
                end
            end
            ST_INIT:
            begin
                var_next   = hash_reg;
                round_next = '0;
                phase_next = PH_READ_A;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                unique case (phase_reg)
                    PH_READ_A:
                    begin
                        ra0        = idx + 4'd1;
                        ra1        = idx - 4'd2;
                        hk_next    = var_reg[7] + ROUND_K[round_reg];
                        phase_next = PH_READ_B;
                    end
                    PH_READ_B:
                    begin
                        ra0        = idx;
                        ra1        = idx + 4'd9;
                        sig_next   = small_sigma0(rd0_reg) + small_sigma1(rd1_reg);
                        phase_next = PH_SCHED;
                    end
                    PH_SCHED:
                    begin
                        if (round_reg[5:4] == 2'd0)
                        begin
                            w_next = rd0_reg;
                        end
                        else
                        begin
                            w_next    = w_sched;
                            mem_we    = 1'b1;
                            mem_waddr = idx;
                            mem_wdata = w_sched;
                        end
                        phase_next = PH_ADD;
                    end
                    PH_ADD:
                    begin
                        t1a_next   = hk_reg + w_reg;
                        phase_next = PH_UPDATE;
                    end
                    PH_UPDATE:
                    begin
                        var_next[7] = var_reg[6];
                        var_next[6] = var_reg[5];
                        var_next[5] = var_reg[4];
                        var_next[4] = var_reg[3] + t1;
                        var_next[3] = var_reg[2];
                        var_next[2] = var_reg[1];
                        var_next[1] = var_reg[0];
                        var_next[0] = t1 + t2;
                        phase_next  = PH_READ_A;
                        if (round_reg == 6'(ROUNDS - 1))
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            round_next = round_reg + 6'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_READ_A;
                    end
                endcase
            end
            ST_FINISH:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + var_reg[i];
                end
                unique case (cont_reg)
                    CONT_IDLE:
                    begin
                        state_next = ST_IDLE;
                    end
                    CONT_PAD:
                    begin
                        state_next = ST_PAD_FIRST;
                    end
                    CONT_FILL:
                    begin
                        fill_next     = '0;
                        len_pass_next = 1'b1;
                        state_next    = ST_PAD_FILL;
                    end
                    CONT_DIGEST:
                    begin
                        out_idx_next = '0;
                        state_next   = ST_DIGEST;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIGEST:
            begin
                if (digest_ready)
                begin
                    if (out_idx_reg == 3'd7)
                    begin
                        hash_next    = HASH_IV;
                        bit_len_next = '0;
                        pos_next     = '0;
                        out_idx_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_READ_A;
            cont_reg     <= CONT_IDLE;
            round_reg    <= '0;
            pos_reg      <= '0;
            fill_reg     <= '0;
            len_pass_reg <= 1'b0;
            out_idx_reg  <= '0;
            bit_len_reg  <= '0;
            hash_reg     <= HASH_IV;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cont_reg     <= cont_next;
            round_reg    <= round_next;
            pos_reg      <= pos_next;
            fill_reg     <= fill_next;
            len_pass_reg <= len_pass_next;
            out_idx_reg  <= out_idx_next;
            bit_len_reg  <= bit_len_next;
            hash_reg     <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        var_reg  <= var_next;
        hk_reg   <= hk_next;
        sig_reg  <= sig_next;
        w_reg    <= w_next;
        t1a_reg  <= t1a_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sched_mem[mem_waddr] <= mem_wdata;
        end
        rd0_reg <= sched_mem[ra0];
        rd1_reg <= sched_mem[ra1];
    end

endmodule

>>> tb/sha256_message_digest_tb.sv
// Self-checking testbench for the SHA-256 message digest block with its own hash predictor.
module sha256_message_digest_tb;
    import sha256_pkg::*;

    localparam int RANDOM_ITEMS = 330;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 50;
    localparam int MAX_WAIT = 8;
    localparam int MAX_REPORTS = 40;
    localparam logic [5:0] LENGTH_SLOT = 6'd56;
    localparam int BOUNDARY_LENGTHS [6] = '{55, 56, 63, 64, 119, 120};

    logic         clk = 1'b0;
    logic         rst_n;
    logic         msg_valid;
    logic         msg_ready;
    msg_beat_t    msg;
    logic         digest_valid;
    logic         digest_ready;
    digest_beat_t digest;

    word_t        running_hash [8];
    word_t        block_buf [16];
    logic [63:0]  message_bits;
    logic [5:0]   fill_pos;
    digest_beat_t expected_digest [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;

    sha256_message_digest dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[sha256_message_digest] ERROR");
            $finish;
        end
    end

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void start_new_digest();
        for (int i = 0; i < 8; i++)
            running_hash[i] = HASH_IV[i];
        message_bits = '0;
        fill_pos = '0;
    endfunction

    function automatic void compress_block();
        word_t sched [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
                sched[i] = block_buf[i];
            else
                sched[i] = sched[i - 16] + sched[i - 7]
                    + (rotr(sched[i - 15], 7) ^ rotr(sched[i - 15], 18) ^ (sched[i - 15] >> 3))
                    + (rotr(sched[i - 2], 17) ^ rotr(sched[i - 2], 19) ^ (sched[i - 2] >> 10));
        end
        for (int i = 0; i < 8; i++)
            v[i] = running_hash[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--)
                v[j] = v[j - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            running_hash[i] = running_hash[i] + v[i];
    endfunction

    function automatic void pack_byte(logic [7:0] value);
        if (fill_pos[1:0] == 2'd0)
            block_buf[fill_pos[5:2]] = '0;
        block_buf[fill_pos[5:2]] |= word_t'(value) << (8 * (3 - fill_pos[1:0]));
        fill_pos = fill_pos + 6'd1;
    endfunction

    // Advances the hash over one accepted beat and queues the digest words it releases.
    function automatic void absorb_beat(msg_beat_t beat);
        digest_beat_t word_beat;
        if (beat.has_byte)
        begin
            pack_byte(beat.data_byte);
            message_bits = message_bits + 64'd8;
            if (fill_pos == 6'd0)
                compress_block();
        end
        if (!beat.end_of_message)
            return;
        pack_byte(PAD_BYTE);
        if (fill_pos > LENGTH_SLOT || fill_pos == 6'd0)
        begin
            while (fill_pos != 6'd0)
                pack_byte(8'h00);
            compress_block();
        end
        while (fill_pos != LENGTH_SLOT)
            pack_byte(8'h00);
        block_buf[14] = message_bits[63:32];
        block_buf[15] = message_bits[31:0];
        fill_pos = '0;
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            word_beat.digest_word = running_hash[i];
            word_beat.word_index = 3'(i);
            word_beat.last_word = (i == 7);
            expected_digest = {expected_digest, word_beat};
        end
        start_new_digest();
    endfunction

    function automatic int draw_wait(bit eager);
        if (eager)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("digest mismatch on %s: got %h, expected %h", field, got, want);
    endtask

    task automatic send_beat(logic [7:0] data_byte, logic has_byte, logic end_of_message);
        msg_beat_t beat;
        int gap;
        beat.data_byte = data_byte;
        beat.has_byte = has_byte;
        beat.end_of_message = end_of_message;
        gap = draw_wait(tx_eager);
        if (gap > 0)
        begin
            msg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg <= beat;
        do @(negedge clk); while (!msg_ready);
        @(posedge clk);
        absorb_beat(beat);
    endtask

    task automatic test_idle_beats();
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
    endtask

    task automatic test_empty_message();
        send_beat(8'hA5, 1'b0, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_end_without_byte();
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        bit end_with_byte;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    len = BOUNDARY_LENGTHS[$urandom_range(0, 5)];
                else
                    len = $urandom_range(52, 130);
            end
            else
                len = $urandom_range(0, 12);
            end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    sent++;
                end
                send_beat(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (i == len - 1));
            end
            if (!end_with_byte)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent += end_with_byte ? len : len + 1;
        end
    endtask

    initial
    begin
        int stall;
        digest_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_wait(rx_eager);
            if (stall > 0)
            begin
                digest_ready <= 1'b0;
                do @(negedge clk); while (!digest_valid);
                repeat (stall) @(posedge clk);
            end
            digest_ready <= 1'b1;
            do @(negedge clk); while (!digest_valid);
            @(posedge clk);
        end
    end

    initial
    begin
        digest_beat_t got;
        digest_beat_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && digest_valid && digest_ready)
            begin
                got = digest;
                if (expected_digest.size() == 0)
                    report_mismatch("unexpected beat", got.digest_word, '0);
                else
                begin
                    want = expected_digest.pop_front();
                    if (got.digest_word !== want.digest_word)
                        report_mismatch("digest_word", got.digest_word, want.digest_word);
                    if (got.word_index !== want.word_index)
                        report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
                    if (got.last_word !== want.last_word)
                        report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
                end
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        msg_valid <= 1'b0;
        msg <= '0;
        start_new_digest();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_beats();
        test_empty_message();
        test_byte_extremes();
        test_end_without_byte();
        test_random_messages();

        msg_valid <= 1'b0;
        while (expected_digest.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[sha256_message_digest] OK");
        else
            $display("[sha256_message_digest] ERROR");
        $finish;
    end
endmodule
